### design/bca_pkg.sv
// Package for the bitmap cell allocator: field widths, command and status
// codes, and the request/result structs shared by the engine and top level.
// No dependencies.
`default_nettype none

package bca_pkg;

   localparam int FIELD_W  = 11;
   localparam int STATUS_W = 2;

   localparam logic CMD_TAKE = 1'b0;
   localparam logic CMD_GIVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_ROOM   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd2;

   typedef struct packed {
      logic               command;
      logic [FIELD_W-1:0] amount;
      logic [FIELD_W-1:0] end_address;
   } bca_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  result_address;
      logic [FIELD_W-1:0]  free_cells;
   } bca_rsp_type;

endpackage

`default_nettype wire

### design/bca_map_ram.sv
// One-bit-wide occupancy memory: one write port, one read port with
// registered read data. No package dependencies.
`default_nettype none

module bca_map_ram #(
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic                     wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic                     rd_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/bca_engine.sv
// Allocation sequencer: clears the map after reset, then walks it one cell
// per cycle for take and give-back requests. Depends on bca_pkg, bca_map_ram.
`default_nettype none

module bca_engine #(
   parameter int CELLS = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire bca_pkg::bca_req_type req,
   output      logic                 idle,
   output      logic                 done,
   output      bca_pkg::bca_rsp_type rsp,
   input  wire logic                 rsp_ack
);

   import bca_pkg::*;

   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int CMP_W = (CW > FIELD_W) ? CW : FIELD_W;

   localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
   localparam logic [CMP_W-1:0] CELLS_CMP = CMP_W'(CELLS);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_addr_ff, pend_addr_in;
   logic [AW-1:0]       last_ff, last_in;
   logic                issued_last_ff, issued_last_in;
   logic                cmd_ff, cmd_in;
   logic [CW-1:0]       remain_ff, remain_in;
   logic [CW-1:0]       free_ff, free_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [FIELD_W-1:0]  addr_ff, addr_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic                ram_wdata;
   logic                ram_re;
   logic                ram_rdata;
   logic                finish;

   logic [CMP_W-1:0]    amount_w;
   logic [CMP_W-1:0]    end_w;
   logic [CMP_W-1:0]    free_w;
   logic [CMP_W-1:0]    start_w;

   assign amount_w = CMP_W'(req.amount);
   assign end_w    = CMP_W'(req.end_address);
   assign free_w   = CMP_W'(free_ff);
   assign start_w  = end_w - amount_w;

   bca_map_ram #(
      .DEPTH(CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      pend_in        = 1'b0;
      pend_addr_in   = pend_addr_ff;
      last_in        = last_ff;
      issued_last_in = issued_last_ff;
      cmd_in         = cmd_ff;
      remain_in      = remain_ff;
      free_in        = free_ff;
      status_in      = status_ff;
      addr_in        = addr_ff;
      ram_we         = 1'b0;
      ram_waddr      = pend_addr_ff;
      ram_wdata      = 1'b0;
      ram_re         = 1'b0;
      finish         = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ptr_in    = ptr_ff + AW'(1);
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in         = req.command;
               status_in      = STATUS_DONE;
               addr_in        = '0;
               issued_last_in = 1'b0;
               ptr_in         = '0;
               if (req.command == CMD_TAKE) begin
                  last_in   = LAST_CELL;
                  remain_in = CW'(amount_w);
                  if (amount_w == '0) begin
                     state_in = ST_HOLD;
                  end else if (amount_w > free_w) begin
                     status_in = STATUS_NO_ROOM;
                     state_in  = ST_HOLD;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  ptr_in  = AW'(start_w);
                  last_in = AW'(end_w - CMP_W'(1));
                  if (amount_w > end_w || end_w > CELLS_CMP) begin
                     status_in = STATUS_BAD_RANGE;
                     state_in  = ST_HOLD;
                  end else if (amount_w == '0) begin
                     addr_in  = req.end_address;
                     state_in = ST_HOLD;
                  end else begin
                     addr_in  = FIELD_W'(start_w);
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // Retire the cell read last cycle, then issue the next read.
            if (pend_ff) begin
               if (cmd_ff == CMD_TAKE) begin
                  if (!ram_rdata) begin
                     ram_we    = 1'b1;
                     ram_wdata = 1'b1;
                     remain_in = remain_ff - CW'(1);
                     free_in   = free_ff - CW'(1);
                     if (remain_ff == CW'(1)) begin
                        finish  = 1'b1;
                        addr_in = FIELD_W'(CW'(pend_addr_ff) + CW'(1));
                     end
                  end
               end else begin
                  if (ram_rdata) begin
                     ram_we  = 1'b1;
                     free_in = free_ff + CW'(1);
                  end
                  if (pend_addr_ff == last_ff) begin
                     finish = 1'b1;
                  end
               end
            end
            if (finish) begin
               state_in = ST_HOLD;
            end else if (!issued_last_ff) begin
               ram_re         = 1'b1;
               pend_in        = 1'b1;
               pend_addr_in   = ptr_ff;
               ptr_in         = ptr_ff + AW'(1);
               issued_last_in = (ptr_ff == last_ff);
            end
         end
         ST_HOLD: begin
            if (rsp_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         ptr_ff         <= '0;
         pend_ff        <= 1'b0;
         issued_last_ff <= 1'b0;
         free_ff        <= CW'(CELLS);
      end else begin
         state_ff       <= state_in;
         ptr_ff         <= ptr_in;
         pend_ff        <= pend_in;
         issued_last_ff <= issued_last_in;
         free_ff        <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      last_ff      <= last_in;
      cmd_ff       <= cmd_in;
      remain_ff    <= remain_in;
      status_ff    <= status_in;
      addr_ff      <= addr_in;
   end

   assign idle               = (state_ff == ST_IDLE);
   assign done               = (state_ff == ST_HOLD);
   assign rsp.status         = status_ff;
   assign rsp.result_address = addr_ff;
   assign rsp.free_cells     = FIELD_W'(free_ff);

endmodule

`default_nettype wire

### design/bitmap_cell_allocator_core.sv
// Top level of the bitmap cell allocator: request/response handshakes and
// the response register. Depends on bca_pkg and bca_engine.
`default_nettype none

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  command, amount, end_address
// rsp      out        rsp_valid/rsp_stall  status, result_address, free_cells
//
// After reset the occupancy map is cleared one cell per cycle, with
// req_stall high. A take walks the map from cell 0 one cell per cycle
// until it has claimed the requested amount; a give-back walks only its
// range, amount cells. Rejected and zero-size requests skip the walk.
// The rate is set by the single read/write port pair of the map
// memory. One request is in flight at a time; the next is taken once
// the result has moved into the response register, even while that
// register is stalled.

module bitmap_cell_allocator_core #(
   parameter int CELLS = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic                            req_command,
   input  wire logic [bca_pkg::FIELD_W-1:0]     req_amount,
   input  wire logic [bca_pkg::FIELD_W-1:0]     req_end_address,

   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [bca_pkg::STATUS_W-1:0]    rsp_status,
   output      logic [bca_pkg::FIELD_W-1:0]     rsp_result_address,
   output      logic [bca_pkg::FIELD_W-1:0]     rsp_free_cells
);

   import bca_pkg::*;

   bca_req_type eng_req;
   bca_rsp_type eng_rsp;
   logic        eng_idle;
   logic        eng_done;
   logic        eng_ack;
   logic        req_take;

   logic        rsp_valid_ff, rsp_valid_in;
   bca_rsp_type rsp_data_ff;

   // Take a transaction only while the sequencer sits idle.
   assign req_stall = !eng_idle;
   assign req_take  = req_valid && eng_idle;

   assign eng_req.command     = req_command;
   assign eng_req.amount      = req_amount;
   assign eng_req.end_address = req_end_address;

   bca_engine #(
      .CELLS(CELLS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (req_take),
      .req     (eng_req),
      .idle    (eng_idle),
      .done    (eng_done),
      .rsp     (eng_rsp),
      .rsp_ack (eng_ack)
   );

   // Move a finished result into the response register when it is empty
   // or being drained this cycle; otherwise hold it in the sequencer.
   assign eng_ack = eng_done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eng_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_ack) begin
         rsp_data_ff <= eng_rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_data_ff.status;
   assign rsp_result_address = rsp_data_ff.result_address;
   assign rsp_free_cells     = rsp_data_ff.free_cells;

endmodule

`default_nettype wire
